// ===== src/pod_pkg.sv =====
// ----------------------------------------------------------------------------
// pod_pkg: shared types and codes of the priority job dispatcher
// Command codes and the decoded command that passes from front to back end.
// ----------------------------------------------------------------------------
package pod_pkg;

   localparam logic [2:0] CMD_ADD_TAIL   = 3'd0;
   localparam logic [2:0] CMD_ADD_HEAD   = 3'd1;
   localparam logic [2:0] CMD_CANCEL_ONE = 3'd2;
   localparam logic [2:0] CMD_CANCEL_ALL = 3'd3;
   localparam logic [2:0] CMD_SUSPEND    = 3'd4;
   localparam logic [2:0] CMD_RESUME     = 3'd5;
   localparam logic [2:0] CMD_FINISH     = 3'd6;
   localparam logic [2:0] CMD_NOP        = 3'd7;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] job_tag;
      logic [1:0] prio_level;
      logic [7:0] purge_id;
   } job_cmd_type;

   typedef struct packed {
      logic       dispatch_valid;
      logic [7:0] dispatch_tag;
      logic       dispatch_cancelled;
      logic       running_cancel_mark;
      logic       busy_res;
      logic       halted;
      logic       push_dropped;
   } rsp_beat_type;

endpackage

// ===== src/pod_if.sv =====
// ----------------------------------------------------------------------------
// pod channel interfaces
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface pod_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [7:0] job_tag;
   logic [1:0] prio_level;
   logic [7:0] purge_id;
   modport source (output valid, cmd, job_tag, prio_level, purge_id, input ready);
   modport sink   (input valid, cmd, job_tag, prio_level, purge_id, output ready);
endinterface

interface pod_rsp_if;
   logic       valid;
   logic       ready;
   logic       dispatch_valid;
   logic [7:0] dispatch_tag;
   logic       dispatch_cancelled;
   logic       running_cancel_mark;
   logic       busy_res;
   logic       halted;
   logic       push_dropped;
   modport source (output valid, dispatch_valid, dispatch_tag, dispatch_cancelled,
                   running_cancel_mark, busy_res, halted, push_dropped,
                   input ready);
   modport sink   (input valid, dispatch_valid, dispatch_tag, dispatch_cancelled,
                   running_cancel_mark, busy_res, halted, push_dropped,
                   output ready);
endinterface

// ===== src/pod_front.sv =====
// ----------------------------------------------------------------------------
// pod_front: command intake
// Takes command beats, folds unused codes to a no-op and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pod_front
   import pod_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   pod_req_if.sink      req_ch,
   output logic         op_valid,
   output job_cmd_type  op_data,
   input  logic         op_ready
);

   job_cmd_type fifo_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;
   job_cmd_type beat;

   always_comb begin
      beat.cmd        = req_ch.cmd;
      beat.job_tag    = req_ch.job_tag;
      beat.prio_level = req_ch.prio_level;
      beat.purge_id   = req_ch.purge_id;
      if (req_ch.cmd > CMD_FINISH) beat.cmd = CMD_NOP;
   end

   assign req_ch.ready = (count_ff != 2'd2);
   assign push     = req_ch.valid && req_ch.ready;
   assign op_valid = (count_ff != 2'd0);
   assign pop      = op_valid && op_ready;
   assign op_data  = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) fifo_ff[wr_ptr_ff] <= beat;
   end

endmodule

// ===== src/pod_back.sv =====
// ----------------------------------------------------------------------------
// pod_back: command execution
// Sequencer over per-level circular queues in one slot memory: purge and
// cancel scans, insertion, dispatch, and the result register.
// ----------------------------------------------------------------------------
module pod_back
   import pod_pkg::*;
#(
   parameter int NUM_LEVELS  = 4,
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         op_valid,
   input  job_cmd_type  op_data,
   output logic         op_ready,
   pod_rsp_if.source    rsp_ch
);

   localparam int TW     = (TAG_BITS < 8) ? TAG_BITS : 8;
   localparam int LVW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOTS  = NUM_LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W = $clog2(SLOTS);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SCAN_RD = 3'd1;
   localparam logic [2:0] ST_SCAN_PR = 3'd2;
   localparam logic [2:0] ST_INSERT  = 3'd3;
   localparam logic [2:0] ST_DISP_RD = 3'd4;
   localparam logic [2:0] ST_DISP_PR = 3'd5;
   localparam logic [2:0] ST_RESULT  = 3'd6;

   typedef struct packed {
      logic [TW-1:0] tag;
      logic [7:0]    pid;
      logic          canc;
   } slot_type;

   function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(logic [LVW-1:0] lv, logic [IDX_W-1:0] ix);
      return ADDR_W'(int'(lv) * QUEUE_DEPTH + int'(ix));
   endfunction

   slot_type          mem [SLOTS];
   slot_type          rd_data_ff;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   slot_type          wr_data;

   logic [2:0]        state_ff, state_in;
   job_cmd_type       op_ff, op_in;
   logic [FILL_W-1:0] fill_ff [NUM_LEVELS];
   logic [FILL_W-1:0] fill_in [NUM_LEVELS];
   logic [IDX_W-1:0]  head_ff [NUM_LEVELS];
   logic [IDX_W-1:0]  head_in [NUM_LEVELS];
   logic [LVW-1:0]    lvl_ff, lvl_in;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic [FILL_W-1:0] keep_ff, keep_in;
   logic              run_valid_ff, run_valid_in;
   logic [TW-1:0]     run_tag_ff, run_tag_in;
   logic [7:0]        run_pid_ff, run_pid_in;
   logic              run_canc_ff, run_canc_in;
   logic              susp_ff, susp_in;
   logic              dropped_ff, dropped_in;
   logic              started_ff, started_in;
   logic [TW-1:0]     dtag_ff, dtag_in;
   logic              dcanc_ff, dcanc_in;
   logic              out_valid_ff, out_valid_in;
   rsp_beat_type      out_ff, out_in;

   logic              is_purge;
   logic [TW-1:0]     op_tag, in_tag;
   logic [LVW-1:0]    ins_lvl, pick_lvl;
   logic              level_ok, pick_found, any_fill, out_load;
   logic [FILL_W-1:0] cur_fill;
   logic [IDX_W-1:0]  cur_head;

   assign is_purge = (op_ff.cmd == CMD_ADD_TAIL) || (op_ff.cmd == CMD_ADD_HEAD);
   assign op_tag   = op_ff.job_tag[TW-1:0];
   assign in_tag   = op_data.job_tag[TW-1:0];
   assign ins_lvl  = LVW'(op_ff.prio_level);
   assign level_ok = int'(op_ff.prio_level) < NUM_LEVELS;
   assign cur_fill = fill_ff[lvl_ff];
   assign cur_head = head_ff[lvl_ff];
   assign op_ready = (state_ff == ST_IDLE);
   assign out_load = (state_ff == ST_RESULT) && (!out_valid_ff || rsp_ch.ready);

   always_comb begin
      pick_found = 1'b0;
      pick_lvl   = '0;
      any_fill   = 1'b0;
      for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
         if (fill_ff[k] != '0) begin
            pick_found = 1'b1;
            pick_lvl   = LVW'(k);
            any_fill   = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      lvl_in       = lvl_ff;
      idx_in       = idx_ff;
      keep_in      = keep_ff;
      run_valid_in = run_valid_ff;
      run_tag_in   = run_tag_ff;
      run_pid_in   = run_pid_ff;
      run_canc_in  = run_canc_ff;
      susp_in      = susp_ff;
      dropped_in   = dropped_ff;
      started_in   = started_ff;
      dtag_in      = dtag_ff;
      dcanc_in     = dcanc_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = rd_data_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (op_valid) begin
               op_in      = op_data;
               dropped_in = 1'b0;
               started_in = 1'b0;
               dtag_in    = '0;
               dcanc_in   = 1'b0;
               lvl_in     = '0;
               idx_in     = '0;
               keep_in    = '0;
               unique case (op_data.cmd)
                  CMD_ADD_TAIL, CMD_ADD_HEAD, CMD_CANCEL_ONE: state_in = ST_SCAN_RD;
                  CMD_CANCEL_ALL: begin
                     for (int k = 0; k < NUM_LEVELS; k++) fill_in[k] = '0;
                     if (run_valid_ff) run_canc_in = 1'b1;
                     state_in = ST_RESULT;
                  end
                  CMD_SUSPEND: begin
                     susp_in  = 1'b1;
                     state_in = ST_RESULT;
                  end
                  CMD_RESUME: begin
                     susp_in  = 1'b0;
                     state_in = susp_ff ? ST_DISP_RD : ST_RESULT;
                  end
                  CMD_FINISH: begin
                     if (run_valid_ff && run_tag_ff == in_tag) begin
                        run_valid_in = 1'b0;
                        run_canc_in  = 1'b0;
                     end
                     state_in = ST_DISP_RD;
                  end
                  default: state_in = ST_RESULT;
               endcase
            end
         end
         ST_SCAN_RD: begin
            if (idx_ff >= cur_fill) begin
               if (is_purge) fill_in[lvl_ff] = keep_ff;
               idx_in  = '0;
               keep_in = '0;
               if (lvl_ff == LVW'(NUM_LEVELS - 1)) begin
                  if (is_purge) begin
                     if (run_valid_ff && run_pid_ff == op_ff.purge_id) run_canc_in = 1'b1;
                     state_in = ST_INSERT;
                  end else begin
                     if (run_valid_ff && run_tag_ff == op_tag) run_canc_in = 1'b1;
                     state_in = ST_RESULT;
                  end
               end else begin
                  lvl_in = lvl_ff + 1'b1;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = slot_addr(lvl_ff, wrap_add(cur_head, IDX_W'(idx_ff)));
               state_in = ST_SCAN_PR;
            end
         end
         ST_SCAN_PR: begin
            if (is_purge) begin
               if (rd_data_ff.pid != op_ff.purge_id) begin
                  wr_en   = 1'b1;
                  wr_addr = slot_addr(lvl_ff, wrap_add(cur_head, IDX_W'(keep_ff)));
                  keep_in = keep_ff + 1'b1;
               end
            end else if (rd_data_ff.tag == op_tag) begin
               wr_en        = 1'b1;
               wr_addr      = slot_addr(lvl_ff, wrap_add(cur_head, IDX_W'(idx_ff)));
               wr_data.canc = 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = ST_SCAN_RD;
         end
         ST_INSERT: begin
            wr_data.tag  = op_tag;
            wr_data.pid  = op_ff.purge_id;
            wr_data.canc = 1'b0;
            if (!level_ok || fill_ff[ins_lvl] >= FILL_W'(QUEUE_DEPTH)) begin
               dropped_in = 1'b1;
            end else begin
               wr_en = 1'b1;
               if (op_ff.cmd == CMD_ADD_HEAD) begin
                  head_in[ins_lvl] = (head_ff[ins_lvl] == '0) ? IDX_W'(QUEUE_DEPTH - 1)
                                                             : head_ff[ins_lvl] - 1'b1;
                  wr_addr = slot_addr(ins_lvl, head_in[ins_lvl]);
               end else begin
                  wr_addr = slot_addr(ins_lvl,
                                      wrap_add(head_ff[ins_lvl], IDX_W'(fill_ff[ins_lvl])));
               end
               fill_in[ins_lvl] = fill_ff[ins_lvl] + 1'b1;
            end
            state_in = ST_DISP_RD;
         end
         ST_DISP_RD: begin
            if (run_valid_ff || susp_ff || !pick_found) begin
               state_in = ST_RESULT;
            end else begin
               lvl_in   = pick_lvl;
               rd_en    = 1'b1;
               rd_addr  = slot_addr(pick_lvl, head_ff[pick_lvl]);
               state_in = ST_DISP_PR;
            end
         end
         ST_DISP_PR: begin
            run_valid_in    = 1'b1;
            run_tag_in      = rd_data_ff.tag;
            run_pid_in      = rd_data_ff.pid;
            run_canc_in     = rd_data_ff.canc;
            head_in[lvl_ff] = wrap_add(cur_head, IDX_W'(1));
            fill_in[lvl_ff] = cur_fill - 1'b1;
            started_in      = 1'b1;
            dtag_in         = rd_data_ff.tag;
            dcanc_in        = rd_data_ff.canc;
            state_in        = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_in                     = out_ff;
      out_valid_in               = out_valid_ff;
      if (out_load) begin
         out_valid_in               = 1'b1;
         out_in.dispatch_valid      = started_ff;
         out_in.dispatch_tag        = 8'(dtag_ff);
         out_in.dispatch_cancelled  = dcanc_ff;
         out_in.running_cancel_mark = run_valid_ff && run_canc_ff;
         out_in.busy_res            = run_valid_ff || any_fill;
         out_in.halted              = susp_ff;
         out_in.push_dropped        = dropped_ff;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         for (int k = 0; k < NUM_LEVELS; k++) begin
            fill_ff[k] <= '0;
            head_ff[k] <= '0;
         end
         run_valid_ff <= 1'b0;
         run_tag_ff   <= '0;
         run_pid_ff   <= '0;
         run_canc_ff  <= 1'b0;
         susp_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         run_valid_ff <= run_valid_in;
         run_tag_ff   <= run_tag_in;
         run_pid_ff   <= run_pid_in;
         run_canc_ff  <= run_canc_in;
         susp_ff      <= susp_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff      <= op_in;
      lvl_ff     <= lvl_in;
      idx_ff     <= idx_in;
      keep_ff    <= keep_in;
      dropped_ff <= dropped_in;
      started_ff <= started_in;
      dtag_ff    <= dtag_in;
      dcanc_ff   <= dcanc_in;
      out_ff     <= out_in;
   end

   assign rsp_ch.valid               = out_valid_ff;
   assign rsp_ch.dispatch_valid      = out_ff.dispatch_valid;
   assign rsp_ch.dispatch_tag        = out_ff.dispatch_tag;
   assign rsp_ch.dispatch_cancelled  = out_ff.dispatch_cancelled;
   assign rsp_ch.running_cancel_mark = out_ff.running_cancel_mark;
   assign rsp_ch.busy_res            = out_ff.busy_res;
   assign rsp_ch.halted              = out_ff.halted;
   assign rsp_ch.push_dropped        = out_ff.push_dropped;

   // compaction never writes ahead of the read point
   a_keep_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_PR) |-> (keep_ff <= idx_ff))
      else $error("purge write index ahead of scan");

   a_disp_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DISP_PR) |=> run_valid_ff)
      else $error("dispatch did not start a job");

   a_disp_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DISP_RD && !run_valid_ff && !susp_ff && pick_found)
      |-> (fill_ff[pick_lvl] != '0))
      else $error("dispatch from empty level");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT && !dropped_in) |=> (fill_ff[ins_lvl] <= FILL_W'(QUEUE_DEPTH)))
      else $error("queue overfilled");

endmodule

// ===== src/priority_op_queue_dispatcher_unit.sv =====
// ----------------------------------------------------------------------------
// Steps, acceptance to result beat: a push scans every queued job on all levels,
// inserts, then tries a dispatch; cancel-one scans every queued job; other
// commands go to the result, some by way of a dispatch. The back end runs one
// command at a time; the front queue holds two more. Result stalls hold the back end.
// Reset: synchronous; clears queue fill counts, running job and suspend flag.
// Slot memory is not cleared; no clearing pass.
// ----------------------------------------------------------------------------
// priority_op_queue_dispatcher_unit: strict-priority job dispatcher
// Front end buffers command beats; back end runs them on the slot queues.
// ----------------------------------------------------------------------------
module priority_op_queue_dispatcher_unit
   import pod_pkg::*;
#(
   parameter int NUM_LEVELS  = 4,
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 8
) (
   input  logic      clock,
   input  logic      reset,
   pod_req_if.sink   req_ch,
   pod_rsp_if.source rsp_ch
);

   logic        op_valid, op_ready;
   job_cmd_type op_data;

   pod_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .op_valid (op_valid),
      .op_data  (op_data),
      .op_ready (op_ready)
   );

   pod_back #(
      .NUM_LEVELS  (NUM_LEVELS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_data  (op_data),
      .op_ready (op_ready),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== test/pod_tb_if.sv =====
// ----------------------------------------------------------------------------
// pod_tb_if: testbench-side handle on the dispatcher channels
// Holds the command and result channel instances used by the test top.
// ----------------------------------------------------------------------------
interface pod_tb_chan;
   pod_req_if req_ch ();
   pod_rsp_if rsp_ch ();
endinterface

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the priority job dispatcher
// Drives command beats through a directed table and then random job traffic,
// predicts every result beat with a behavioural queue model and compares them.
// ----------------------------------------------------------------------------
module tb;
   import pod_pkg::*;

   localparam int LEVELS    = 4;
   localparam int DEPTH     = 16;
   localparam int RAND_BEATS = 1250;
   localparam int WDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pod_tb_chan chans ();

   priority_op_queue_dispatcher_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (chans.req_ch),
      .rsp_ch (chans.rsp_ch)
   );

   always #4 clock = ~clock;

   // job queues of the predictor
   typedef struct {
      logic [7:0] tag;
      logic [7:0] pid;
      logic       canc;
   } job_slot_type;

   job_slot_type jobq [LEVELS][$];
   logic         run_valid, run_canc, susp;
   logic [7:0]   run_tag, run_pid;

   rsp_beat_type beat_q [$];
   logic         beat_chk [$];   // 1: table row carries a typed-in result
   rsp_beat_type table_q [$];
   int           errors, beats_in, beats_out, dispatches, drops, idle_cycles;
   bit           stim_done;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR beat %0d: %s got %0h expected %0h", beats_out, what, got, want);
      errors++;
   endtask

   function automatic logic start_next(output logic [7:0] t, output logic c);
      t = '0;
      c = 1'b0;
      if (run_valid || susp) return 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
         if (jobq[l].size() != 0) begin
            job_slot_type s;
            s = jobq[l][0];
            jobq[l].delete(0);
            run_valid = 1'b1;
            run_tag = s.tag;
            run_pid = s.pid;
            run_canc = s.canc;
            t = s.tag;
            c = s.canc;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic rsp_beat_type predict_beat(input job_cmd_type b);
      rsp_beat_type r;
      logic [7:0]   t;
      logic         c;
      job_slot_type s;
      r = '0;
      t = '0;
      c = 1'b0;
      case (b.cmd)
         CMD_ADD_TAIL, CMD_ADD_HEAD: begin
            for (int l = 0; l < LEVELS; l++)
               for (int i = jobq[l].size() - 1; i >= 0; i--)
                  if (jobq[l][i].pid == b.purge_id) jobq[l].delete(i);
            if (run_valid && run_pid == b.purge_id) run_canc = 1'b1;
            if (jobq[b.prio_level].size() >= DEPTH) begin
               r.push_dropped = 1'b1;
            end else begin
               s.tag = b.job_tag;
               s.pid = b.purge_id;
               s.canc = 1'b0;
               if (b.cmd == CMD_ADD_HEAD) jobq[b.prio_level] = {s, jobq[b.prio_level]};
               else jobq[b.prio_level] = {jobq[b.prio_level], s};
            end
            r.dispatch_valid = start_next(t, c);
         end
         CMD_CANCEL_ONE: begin
            for (int l = 0; l < LEVELS; l++)
               for (int i = 0; i < jobq[l].size(); i++)
                  if (jobq[l][i].tag == b.job_tag) jobq[l][i].canc = 1'b1;
            if (run_valid && run_tag == b.job_tag) run_canc = 1'b1;
         end
         CMD_CANCEL_ALL: begin
            for (int l = 0; l < LEVELS; l++) jobq[l].delete();
            if (run_valid) run_canc = 1'b1;
         end
         CMD_SUSPEND: susp = 1'b1;
         CMD_RESUME: begin
            if (susp) begin
               susp = 1'b0;
               r.dispatch_valid = start_next(t, c);
            end
         end
         CMD_FINISH: begin
            if (run_valid && run_tag == b.job_tag) begin
               run_valid = 1'b0;
               run_canc = 1'b0;
            end
            r.dispatch_valid = start_next(t, c);
         end
         default: ;
      endcase
      if (r.dispatch_valid) begin
         r.dispatch_tag = t;
         r.dispatch_cancelled = c;
      end
      r.running_cancel_mark = run_valid && run_canc;
      r.busy_res = run_valid;
      for (int l = 0; l < LEVELS; l++)
         if (jobq[l].size() != 0) r.busy_res = 1'b1;
      r.halted = susp;
      return r;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one command beat; blocks until accepted, returns at a falling edge
   task automatic send_beat(input job_cmd_type b, input logic typed,
                            input rsp_beat_type want);
      int           g;
      rsp_beat_type pred;
      g = gap_len();
      if (g != 0) begin
         chans.req_ch.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      chans.req_ch.valid      <= 1'b1;
      chans.req_ch.cmd        <= b.cmd;
      chans.req_ch.job_tag    <= b.job_tag;
      chans.req_ch.prio_level <= b.prio_level;
      chans.req_ch.purge_id   <= b.purge_id;
      @(posedge clock);
      while (!chans.req_ch.ready) @(posedge clock);
      pred = predict_beat(b);
      beat_q = {beat_q, pred};
      beat_chk = {beat_chk, typed};
      table_q = {table_q, want};
      beats_in++;
      @(negedge clock);
   endtask

   function automatic job_cmd_type mk(input logic [2:0] c, input logic [7:0] t,
                                      input logic [1:0] l, input logic [7:0] p);
      job_cmd_type b;
      b.cmd = c;
      b.job_tag = t;
      b.prio_level = l;
      b.purge_id = p;
      return b;
   endfunction

   function automatic rsp_beat_type mkr(input logic dv, input logic [7:0] dt,
                                        input logic dc, input logic rc,
                                        input logic bz, input logic hl,
                                        input logic dr);
      rsp_beat_type r;
      r = '{dv, dt, dc, rc, bz, hl, dr};
      return r;
   endfunction

   // called at a falling edge; pauses the sender until every result is back
   task automatic drain();
      chans.req_ch.valid <= 1'b0;
      @(posedge clock);
      while (beat_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // directed table
   typedef struct {
      job_cmd_type  b;
      logic         typed;
      rsp_beat_type want;
   } table_row_type;

   table_row_type rows [$];

   task automatic add_row(input job_cmd_type b, input logic typed, input rsp_beat_type want);
      table_row_type row;
      row.b = b;
      row.typed = typed;
      row.want = want;
      rows = {rows, row};
   endtask

   task automatic run_directed();
      add_row(mk(CMD_NOP, 8'hff, 2'd3, 8'hff), 1'b1,
              mkr(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      add_row(mk(CMD_FINISH, 8'h00, 2'd0, 8'h00), 1'b1,
              mkr(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      add_row(mk(CMD_RESUME, 8'h00, 2'd0, 8'h00), 1'b1,
              mkr(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      add_row(mk(CMD_ADD_TAIL, 8'hff, 2'd3, 8'hff), 1'b1,
              mkr(1'b1, 8'hff, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      add_row(mk(CMD_SUSPEND, 8'h00, 2'd0, 8'h00), 1'b1,
              mkr(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
      add_row(mk(CMD_ADD_TAIL, 8'h00, 2'd0, 8'h00), 1'b0, '0);
      add_row(mk(CMD_ADD_HEAD, 8'h11, 2'd0, 8'h01), 1'b0, '0);
      add_row(mk(CMD_ADD_TAIL, 8'h22, 2'd2, 8'h02), 1'b0, '0);
      add_row(mk(CMD_CANCEL_ONE, 8'h00, 2'd0, 8'h00), 1'b0, '0);
      add_row(mk(CMD_CANCEL_ONE, 8'hff, 2'd0, 8'h00), 1'b0, '0);
      // purge of id 0x02 while the running job has id 0xff
      add_row(mk(CMD_ADD_HEAD, 8'h33, 2'd1, 8'h02), 1'b0, '0);
      add_row(mk(CMD_ADD_TAIL, 8'h44, 2'd0, 8'hff), 1'b0, '0);
      add_row(mk(CMD_FINISH, 8'hff, 2'd0, 8'h00), 1'b0, '0);
      add_row(mk(CMD_RESUME, 8'h00, 2'd0, 8'h00), 1'b0, '0);
      add_row(mk(CMD_FINISH, 8'h12, 2'd0, 8'h00), 1'b0, '0);
      add_row(mk(CMD_CANCEL_ALL, 8'h00, 2'd0, 8'h00), 1'b0, '0);
      add_row(mk(CMD_FINISH, 8'h11, 2'd0, 8'h00), 1'b0, '0);
      add_row(mk(CMD_FINISH, 8'h00, 2'd0, 8'h00), 1'b0, '0);
      foreach (rows[i]) send_beat(rows[i].b, rows[i].typed, rows[i].want);
      drain();
      // fill one level past its depth while halted: last push is dropped
      send_beat(mk(CMD_SUSPEND, 8'h00, 2'd0, 8'h00), 1'b0, '0);
      for (int i = 0; i <= DEPTH; i++)
         send_beat(mk(CMD_ADD_TAIL, i[7:0], 2'd1, 8'h80 + i[7:0]), 1'b0, '0);
      send_beat(mk(CMD_ADD_HEAD, 8'haa, 2'd1, 8'h90), 1'b0, '0);
      // full level, yet the purge frees a slot
      send_beat(mk(CMD_ADD_HEAD, 8'hbb, 2'd1, 8'h83), 1'b0, '0);
      send_beat(mk(CMD_RESUME, 8'h00, 2'd0, 8'h00), 1'b0, '0);
      send_beat(mk(CMD_CANCEL_ALL, 8'h00, 2'd0, 8'h00), 1'b0, '0);
   endtask

   // random traffic: mostly pushes and finishes of the running job
   task automatic run_random();
      job_cmd_type b;
      int          p;
      for (int n = 0; n < RAND_BEATS; n++) begin
         p = $urandom_range(0, 99);
         b.job_tag = 8'($urandom_range(0, 15)) +
                     (($urandom_range(0, 3) == 0) ? 8'hf0 : 8'h00);
         if ($urandom_range(0, 19) == 0) b.job_tag = 8'($urandom);
         b.prio_level = 2'($urandom);
         b.purge_id = 8'($urandom_range(0, 23));
         if ($urandom_range(0, 9) == 0) b.purge_id = 8'($urandom);
         if (p < 45)      b.cmd = ($urandom_range(0, 2) == 0) ? CMD_ADD_HEAD : CMD_ADD_TAIL;
         else if (p < 75) begin
            b.cmd = CMD_FINISH;
            if (run_valid && $urandom_range(0, 4) != 0) b.job_tag = run_tag;
         end
         else if (p < 83) b.cmd = CMD_CANCEL_ONE;
         else if (p < 86) b.cmd = CMD_CANCEL_ALL;
         else if (p < 91) b.cmd = CMD_SUSPEND;
         else if (p < 98) b.cmd = CMD_RESUME;
         else             b.cmd = CMD_NOP;
         if (n == RAND_BEATS / 2) drain();
         send_beat(b, 1'b0, '0);
      end
   endtask

   // result side: random stalls, compare at the rising edge
   initial begin
      int g;
      chans.rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         g = 0;
         if ($urandom_range(0, 99) < 35) g = gap_len();
         if (g != 0) begin
            chans.rsp_ch.ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         chans.rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_beat_type got, want;
      logic         chk;
      if (!reset && chans.rsp_ch.valid && chans.rsp_ch.ready) begin
         got = '{chans.rsp_ch.dispatch_valid, chans.rsp_ch.dispatch_tag,
                 chans.rsp_ch.dispatch_cancelled, chans.rsp_ch.running_cancel_mark,
                 chans.rsp_ch.busy_res, chans.rsp_ch.halted, chans.rsp_ch.push_dropped};
         if (beat_q.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
         end else begin
            want = beat_q[0];
            beat_q.delete(0);
            chk = beat_chk[0];
            beat_chk.delete(0);
            if (chk && table_q[0] != want)
               report_mismatch("typed-in row", int'(table_q[0]), int'(want));
            table_q.delete(0);
            if (got.dispatch_valid !== want.dispatch_valid)
               report_mismatch("dispatch_valid", got.dispatch_valid, want.dispatch_valid);
            if (got.dispatch_tag !== want.dispatch_tag)
               report_mismatch("dispatch_tag", got.dispatch_tag, want.dispatch_tag);
            if (got.dispatch_cancelled !== want.dispatch_cancelled)
               report_mismatch("dispatch_cancelled", got.dispatch_cancelled,
                               want.dispatch_cancelled);
            if (got.running_cancel_mark !== want.running_cancel_mark)
               report_mismatch("running_cancel_mark", got.running_cancel_mark,
                               want.running_cancel_mark);
            if (got.busy_res !== want.busy_res)
               report_mismatch("busy_res", got.busy_res, want.busy_res);
            if (got.halted !== want.halted)
               report_mismatch("halted", got.halted, want.halted);
            if (got.push_dropped !== want.push_dropped)
               report_mismatch("push_dropped", got.push_dropped, want.push_dropped);
            dispatches += want.dispatch_valid;
            drops += want.push_dropped;
         end
         beats_out++;
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (chans.req_ch.valid && chans.req_ch.ready) ||
          (chans.rsp_ch.valid && chans.rsp_ch.ready) ||
          (stim_done && beat_q.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("Timeout with %0d results outstanding", beat_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      errors = 0;
      beats_in = 0;
      beats_out = 0;
      dispatches = 0;
      drops = 0;
      idle_cycles = 0;
      stim_done = 1'b0;
      run_valid = 1'b0;
      run_canc = 1'b0;
      run_tag = '0;
      run_pid = '0;
      susp = 1'b0;
      chans.req_ch.valid = 1'b0;
      chans.req_ch.cmd = CMD_NOP;
      chans.req_ch.job_tag = '0;
      chans.req_ch.prio_level = '0;
      chans.req_ch.purge_id = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      stim_done = 1'b1;
      drain();
      repeat (200) @(posedge clock);
      $display("Sent %0d command beats, checked %0d results", beats_in, beats_out);
      $display("Jobs started: %0d, pushes refused: %0d", dispatches, drops);
      if (errors == 0 && beat_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
